// File: design/ile_pkg.sv
`timescale 1ns / 1ps
// Package for the indexed list engine: operation and status codes,
// request and response payload types, and the per-cell operation struct.
// Used by the interfaces and every module of the block.
package ile_pkg;

  localparam int DEFAULT_CAPACITY = 16;

  localparam int KIND_W     = 3;
  localparam int POSITION_W = 16;
  localparam int VALUE_W    = 32;
  localparam int STATUS_W   = 2;
  localparam int COUNT_W    = 5;

  typedef enum logic [KIND_W-1:0] {
    KIND_READ   = 3'd0,
    KIND_FRONT  = 3'd1,
    KIND_BACK   = 3'd2,
    KIND_INSERT = 3'd3,
    KIND_DELETE = 3'd4
  } kind_e;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_DONE  = 2'd0,
    STATUS_RANGE = 2'd1,
    STATUS_FULL  = 2'd2
  } status_e;

  typedef struct packed {
    logic        [KIND_W-1:0]     kind;
    logic signed [POSITION_W-1:0] position;
    logic signed [VALUE_W-1:0]    value;
  } req_t;

  typedef struct packed {
    logic        [STATUS_W-1:0] status;
    logic                       found;
    logic signed [VALUE_W-1:0]  read_value;
    logic        [COUNT_W-1:0]  count;
  } rsp_t;

  // Operation broadcast to every cell in the row for one transfer.
  typedef struct packed {
    logic insert;
    logic remove;
    logic read;
  } cell_op_t;

endpackage

// File: design/ile_stream_if.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces for the request and response streams.
// Payload types come from ile_pkg.
interface ile_req_if import ile_pkg::*; ();
  logic valid;
  logic ready;
  req_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface ile_rsp_if import ile_pkg::*; ();
  logic valid;
  logic ready;
  rsp_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// File: design/ile_cell.sv
`timescale 1ns / 1ps
// One storage cell of the list: holds the entry at a fixed index and
// shifts to or from its neighbors on insert and delete. Uses ile_pkg.
module ile_cell import ile_pkg::*; #(
  parameter int IDX_W = 4,
  parameter int INDEX = 0
) (
  input  logic                      clk_i,
  input  cell_op_t                  op_i,
  input  logic        [IDX_W-1:0]   pos_i,
  input  logic signed [VALUE_W-1:0] value_i,
  input  logic signed [VALUE_W-1:0] prev_i,
  input  logic signed [VALUE_W-1:0] next_i,
  output logic signed [VALUE_W-1:0] data_o,
  output logic        [VALUE_W-1:0] hit_data_o
);

  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);

  logic signed [VALUE_W-1:0] data_q, data_d;

  always_comb begin
    data_d = data_q;
    if (op_i.insert) begin
      if (MY_IDX > pos_i) begin
        data_d = prev_i;
      end else if (MY_IDX == pos_i) begin
        data_d = value_i;
      end
    end else if (op_i.remove) begin
      if (MY_IDX >= pos_i) begin
        data_d = next_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o     = data_q;
  assign hit_data_o = (op_i.read && (MY_IDX == pos_i)) ? data_q : '0;

endmodule

// File: design/ile_ctrl.sv
`timescale 1ns / 1ps
// Control for the indexed list engine: decodes a request, keeps the
// entry count, drives the cell row and holds the response register. Uses ile_pkg.
module ile_ctrl import ile_pkg::*; #(
  parameter int CAPACITY = DEFAULT_CAPACITY,
  parameter int IDX_W    = $clog2(CAPACITY),
  parameter int LEN_W    = $clog2(CAPACITY + 1)
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      req_valid_i,
  output logic                      req_ready_o,
  input  req_t                      req_i,
  output logic                      rsp_valid_o,
  input  logic                      rsp_ready_i,
  output rsp_t                      rsp_o,
  output cell_op_t                  op_o,
  output logic        [IDX_W-1:0]   pos_o,
  input  logic signed [VALUE_W-1:0] rd_data_i
);

  localparam int CMP_W = (LEN_W > POSITION_W) ? LEN_W : POSITION_W;
  localparam logic [LEN_W-1:0] FULL_LEN = LEN_W'(CAPACITY);

  logic [LEN_W-1:0] len_q, len_d;
  logic             rsp_valid_q;
  rsp_t             rsp_q, rsp_d;
  logic             fire;
  logic             nonneg, in_range, beyond, full, not_positive;
  logic [CMP_W-1:0] pos_u, len_ext;

  assign req_ready_o = !rsp_valid_q || rsp_ready_i;
  assign fire        = req_valid_i && req_ready_o;

  assign nonneg       = !req_i.position[POSITION_W-1];
  assign pos_u        = CMP_W'(req_i.position[POSITION_W-2:0]);
  assign len_ext      = CMP_W'(len_q);
  assign in_range     = nonneg && (pos_u < len_ext);
  assign beyond       = nonneg && (pos_u > len_ext);
  assign full         = (len_q == FULL_LEN);
  assign not_positive = !nonneg || (pos_u == '0);

  always_comb begin
    len_d             = len_q;
    op_o              = '0;
    pos_o             = pos_u[IDX_W-1:0];
    rsp_d.status      = STATUS_RANGE;
    rsp_d.found       = 1'b0;
    rsp_d.read_value  = '1;
    case (kind_e'(req_i.kind))
      KIND_READ: begin
        if (in_range) begin
          op_o.read        = 1'b1;
          rsp_d.status     = STATUS_DONE;
          rsp_d.found      = 1'b1;
          rsp_d.read_value = rd_data_i;
        end
      end
      KIND_FRONT, KIND_BACK: begin
        if (full) begin
          rsp_d.status = STATUS_FULL;
        end else begin
          op_o.insert  = fire;
          pos_o        = (kind_e'(req_i.kind) == KIND_FRONT) ? '0 : len_q[IDX_W-1:0];
          len_d        = len_q + 1'b1;
          rsp_d.status = STATUS_DONE;
        end
      end
      KIND_INSERT: begin
        if (beyond) begin
          rsp_d.status = STATUS_RANGE;
        end else if (full) begin
          rsp_d.status = STATUS_FULL;
        end else begin
          op_o.insert  = fire;
          pos_o        = not_positive ? '0 : pos_u[IDX_W-1:0];
          len_d        = len_q + 1'b1;
          rsp_d.status = STATUS_DONE;
        end
      end
      KIND_DELETE: begin
        if (in_range) begin
          op_o.remove  = fire;
          len_d        = len_q - 1'b1;
          rsp_d.status = STATUS_DONE;
        end
      end
      default: begin
      end
    endcase
    rsp_d.count = COUNT_W'(len_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q       <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      if (fire) begin
        len_q <= len_d;
      end
      if (req_ready_o) begin
        rsp_valid_q <= req_valid_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      rsp_q <= rsp_d;
    end
  end

  assign rsp_valid_o = rsp_valid_q;
  assign rsp_o       = rsp_q;

endmodule

// File: design/indexed_list_engine.sv
`timescale 1ns / 1ps
// Indexed list engine: an ordered list of up to CAPACITY signed 32-bit values
// held in a row of cells, with positional read, insert and delete.
//
// Usage:
//   req_i carries one operation per transfer (kind, position, value).
//   rsp_o returns exactly one result per request (status, found,
//   read_value, count) in request order.
//   The result is registered and valid in the cycle after the request
//   transfer. Throughput is one item per cycle while the receiver does
//   not stall; every cell shifts toward or away from its neighbor in the
//   same cycle, so an insert or delete costs the same at any position. A
//   read selects the addressed cell through an OR-combine over the row.
//   When the receiver stalls, the held result stays on rsp_o and req_i is
//   ready only in the cycle the result is taken, so no result is lost.
//   Reset clears the count and the output valid; entry contents are not
//   reset and are only read after they have been written.
// Depends on ile_pkg, ile_stream_if, ile_cell and ile_ctrl.
module indexed_list_engine import ile_pkg::*; #(
  parameter int CAPACITY = DEFAULT_CAPACITY
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  ile_req_if.sink   req_i,
  ile_rsp_if.source rsp_o
);

  localparam int IDX_W = $clog2(CAPACITY);
  localparam int LEN_W = $clog2(CAPACITY + 1);

  cell_op_t                  op;
  logic        [IDX_W-1:0]   pos;
  logic signed [VALUE_W-1:0] cell_data [CAPACITY];
  logic        [VALUE_W-1:0] hit_data  [CAPACITY];
  logic        [VALUE_W-1:0] rd_data;

  ile_ctrl #(
    .CAPACITY (CAPACITY),
    .IDX_W    (IDX_W),
    .LEN_W    (LEN_W)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_i.ready),
    .req_i       (req_i.payload),
    .rsp_valid_o (rsp_o.valid),
    .rsp_ready_i (rsp_o.ready),
    .rsp_o       (rsp_o.payload),
    .op_o        (op),
    .pos_o       (pos),
    .rd_data_i   (signed'(rd_data))
  );

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    ile_cell #(
      .IDX_W (IDX_W),
      .INDEX (i)
    ) u_cell (
      .clk_i      (clk_i),
      .op_i       (op),
      .pos_i      (pos),
      .value_i    (req_i.payload.value),
      .prev_i     (cell_data[(i == 0) ? 0 : i - 1]),
      .next_i     (cell_data[(i == CAPACITY - 1) ? i : i + 1]),
      .data_o     (cell_data[i]),
      .hit_data_o (hit_data[i])
    );
  end

  // Only the addressed cell drives nonzero data, so an OR combines the row.
  always_comb begin
    rd_data = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      rd_data = rd_data | hit_data[i];
    end
  end

endmodule
